@@ design/best_fit_heap_allocator_assert.svh @@
// Assertion macros for the best-fit heap allocator.
// Needs clock and reset in the scope that uses them.
`ifndef BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BFHA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bfha: same-cycle check failed");

// next-cycle implication
`define BFHA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bfha: next-cycle check failed");

`endif

@@ design/bfha_pkg.sv @@
// Shared constants, types and helpers for the best-fit heap allocator.
// No dependencies.
package bfha_pkg;

   localparam int ARENA_BYTES     = 524288;
   localparam int HEADER_BYTES    = 12;
   localparam int MAX_FREE_BLOCKS = 256;
   localparam int ROUND_MASK      = 7;
   localparam int SPLIT_SLACK     = 16;

   localparam int OFF_W   = 19;
   localparam int SIZE_W  = 20;
   localparam int REQ_W   = 20;
   localparam int NEED_W  = 21;
   localparam int TBL_AW  = 8;
   localparam int CNT_W   = 9;
   localparam int MWORD_W = 64;
   localparam int MARK_WORDS = ARENA_BYTES / 256;
   localparam int MARK_AW = 11;

   typedef struct packed {
      logic [OFF_W-1:0]  start;
      logic [SIZE_W-1:0] size;
   } bfha_entry_type;

   localparam int ENTRY_W = OFF_W + SIZE_W;

   localparam logic [2:0] ST_ALLOC    = 3'd0;
   localparam logic [2:0] ST_NOFIT    = 3'd1;
   localparam logic [2:0] ST_ZERO     = 3'd2;
   localparam logic [2:0] ST_FREED    = 3'd3;
   localparam logic [2:0] ST_NULL     = 3'd4;
   localparam logic [2:0] ST_NOTALLOC = 3'd5;
   localparam logic [2:0] ST_INVALID  = 3'd6;
   localparam logic [2:0] ST_FULL     = 3'd7;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_A_RD, S_A_CHK, S_A_PICK, S_A_SPLIT, S_A_MARK, S_A_MARKW,
      S_RM_RD, S_RM_WR, S_PH_RD, S_PH_WR,
      S_F_MARK, S_F_LRD, S_F_LCHK, S_F_SCAN, S_F_SCANW,
      S_C_INIT, S_C_RD0, S_C_GET0, S_C_GET1,
      S_DONE
   } bfha_state_type;

   // lowest set bit: {found, index}
   function automatic logic [6:0] bfha_low_set(input logic [MWORD_W-1:0] w);
      logic [6:0] r;
      r = '0;
      for (int i = MWORD_W - 1; i >= 0; i--) begin
         if (w[i]) r = {1'b1, 6'(i)};
      end
      return r;
   endfunction

endpackage

@@ design/bfha_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule

@@ design/best_fit_heap_allocator.sv @@
// Best-fit heap allocator: top level with sequencer.
// Depends on bfha_pkg, bfha_ram and best_fit_heap_allocator_assert.svh.
//
// Usage:
//  req_* channel carries one transaction: allocate (kind 0, request_bytes) or
//  free (kind 1, free_offset, null_pointer). rsp_* returns one status and
//  block offset per request, in order. Both channels use valid/stall.
//  The free table (offset, size) lives in a 256-entry RAM, the allocated
//  marks in a 2048 x 64-bit RAM, one bit per 4-byte header slot.
//  Work per request, paced by the single table RAM port:
//   allocate: scan the free entries for the best fit, shift entries to
//   remove it and to push a split remainder, then update the mark.
//   free: scan the table for the next free start, scan the mark words,
//   push the block at the head, then coalesce, which restarts at the
//   head after each merge.
//  One request is processed at a time; a new one is taken as soon as the
//  sequencer is idle, even while the previous response waits in its register.
//  After reset a clearing pass zeroes the mark RAM; req_stall stays high
//  meanwhile. While rsp_stall is high a finished response holds
//  and the sequencer waits before loading the next one.
`include "best_fit_heap_allocator_assert.svh"

module best_fit_heap_allocator
   import bfha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_kind,
   input  logic [REQ_W-1:0]  req_request_bytes,
   input  logic [REQ_W-1:0]  req_free_offset,
   input  logic              req_null_pointer,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [OFF_W-1:0]  rsp_block_offset
);

   bfha_state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [MARK_AW-1:0] clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               kind_ff, kind_in;
   logic [NEED_W-1:0]  need_ff, need_in;
   logic [OFF_W-1:0]   h_ff, h_in;
   logic [TBL_AW-1:0]  best_idx_ff, best_idx_in;
   logic [OFF_W-1:0]   best_start_ff, best_start_in;
   logic [SIZE_W-1:0]  best_size_ff, best_size_in;
   logic               found_ff, found_in;
   bfha_entry_type     cur_ff, cur_in;
   bfha_entry_type     push_ff, push_in;
   logic [SIZE_W-1:0]  limit_ff, limit_in;
   logic [MARK_AW-1:0] word_ff, word_in;
   logic [MWORD_W-1:0] mword_ff, mword_in;
   logic [2:0]         status_ff, status_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0]   rsp_offset_ff, rsp_offset_in;

   logic               tbl_we;
   logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
   logic [ENTRY_W-1:0] tbl_wdata, tbl_rdata;
   bfha_entry_type     rd_entry;
   logic               mk_we;
   logic [MARK_AW-1:0] mk_waddr, mk_raddr;
   logic [MWORD_W-1:0] mk_wdata, mk_rdata;

   assign rd_entry = bfha_entry_type'(tbl_rdata);

   bfha_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_FREE_BLOCKS)) u_table (
      .clock(clock), .wr_en(tbl_we), .wr_addr(tbl_waddr), .wr_data(tbl_wdata),
      .rd_addr(tbl_raddr), .rd_data(tbl_rdata)
   );

   bfha_ram #(.WIDTH(MWORD_W), .DEPTH(MARK_WORDS)) u_marks (
      .clock(clock), .wr_en(mk_we), .wr_addr(mk_waddr), .wr_data(mk_wdata),
      .rd_addr(mk_raddr), .rd_data(mk_rdata)
   );

   always_comb begin
      logic [OFF_W-1:0]   hc;
      logic [6:0]         low;
      logic [OFF_W-1:0]   pos;
      logic [MARK_AW:0]   nw;
      logic [SIZE_W-1:0]  end_v;
      logic [NEED_W:0]    split_sum;
      logic               do_push;
      logic [NEED_W-1:0]  link;
      bfha_entry_type     reset_entry;

      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff;
      kind_in       = kind_ff;
      need_in       = need_ff;
      h_in          = h_ff;
      best_idx_in   = best_idx_ff;
      best_start_in = best_start_ff;
      best_size_in  = best_size_ff;
      found_in      = found_ff;
      cur_in        = cur_ff;
      push_in       = push_ff;
      limit_in      = limit_ff;
      word_in       = word_ff;
      mword_in      = mword_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;

      tbl_we    = 1'b0;
      tbl_waddr = idx_ff[TBL_AW-1:0];
      tbl_wdata = tbl_rdata;
      tbl_raddr = idx_ff[TBL_AW-1:0];
      mk_we     = 1'b0;
      mk_waddr  = h_ff[OFF_W-1:8];
      mk_wdata  = mk_rdata;
      mk_raddr  = h_ff[OFF_W-1:8];

      hc          = OFF_W'(req_free_offset - REQ_W'(HEADER_BYTES));
      low         = bfha_low_set(mword_ff);
      pos         = {word_ff, low[5:0], 2'b00};
      nw          = {1'b0, word_ff} + 1'b1;
      end_v       = limit_ff;
      split_sum   = {1'b0, need_ff} + (NEED_W+1)'(HEADER_BYTES + SPLIT_SLACK);
      do_push     = 1'b0;
      link        = NEED_W'(cur_ff.start) + NEED_W'(HEADER_BYTES) + NEED_W'(cur_ff.size);
      reset_entry.start = '0;
      reset_entry.size  = SIZE_W'(ARENA_BYTES - HEADER_BYTES);

      req_stall = (state_ff != S_IDLE);

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            mk_we     = 1'b1;
            mk_waddr  = clr_ff;
            mk_wdata  = '0;
            tbl_we    = 1'b1;
            tbl_waddr = '0;
            tbl_wdata = reset_entry;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == MARK_AW'(MARK_WORDS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               need_in  = (NEED_W'(req_request_bytes) + NEED_W'(ROUND_MASK))
                          & ~NEED_W'(ROUND_MASK);
               h_in     = hc;
               idx_in   = '0;
               found_in = 1'b0;
               if (!req_kind) begin
                  if (req_request_bytes == '0) begin
                     status_in = ST_ZERO;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_A_RD;
                  end
               end else if (req_null_pointer) begin
                  status_in = ST_NULL;
                  state_in  = S_DONE;
               end else if (req_free_offset < REQ_W'(HEADER_BYTES) ||
                            req_free_offset >= REQ_W'(ARENA_BYTES)) begin
                  status_in = ST_INVALID;
                  state_in  = S_DONE;
               end else if (hc[1:0] != 2'b00) begin
                  // headers sit on 4-byte slots only
                  status_in = ST_NOTALLOC;
                  state_in  = S_DONE;
               end else begin
                  mk_raddr = hc[OFF_W-1:8];
                  state_in = S_F_MARK;
               end
            end
         end
         S_A_RD: begin
            if (idx_ff >= count_ff) begin
               state_in = S_A_PICK;
            end else begin
               state_in = S_A_CHK;
            end
         end
         S_A_CHK: begin
            if ({1'b0, rd_entry.size} >= need_ff &&
                (!found_ff || rd_entry.size < best_size_ff)) begin
               found_in      = 1'b1;
               best_idx_in   = idx_ff[TBL_AW-1:0];
               best_start_in = rd_entry.start;
               best_size_in  = rd_entry.size;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_A_RD;
         end
         S_A_PICK: begin
            if (!found_ff) begin
               status_in = ST_NOFIT;
               state_in  = S_DONE;
            end else begin
               h_in     = best_start_ff;
               idx_in   = {1'b0, best_idx_ff};
               state_in = S_RM_RD;
            end
         end
         S_RM_RD: begin
            tbl_raddr = TBL_AW'(idx_ff + 1'b1);
            if (idx_ff + 1'b1 < count_ff) begin
               state_in = S_RM_WR;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = kind_ff ? S_C_INIT : S_A_SPLIT;
            end
         end
         S_RM_WR: begin
            tbl_we   = 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = S_RM_RD;
         end
         S_A_SPLIT: begin
            if ({2'b00, best_size_ff} >= split_sum) begin
               push_in.start = OFF_W'(NEED_W'(best_start_ff) + NEED_W'(HEADER_BYTES) + need_ff);
               push_in.size  = SIZE_W'(NEED_W'(best_size_ff) - need_ff
                                       - NEED_W'(HEADER_BYTES));
               idx_in        = count_ff;
               state_in      = S_PH_RD;
            end else begin
               state_in = S_A_MARK;
            end
         end
         S_PH_RD: begin
            tbl_raddr = TBL_AW'(idx_ff - 1'b1);
            if (idx_ff == '0) begin
               tbl_we    = 1'b1;
               tbl_waddr = '0;
               tbl_wdata = push_ff;
               count_in  = count_ff + 1'b1;
               state_in  = kind_ff ? S_C_INIT : S_A_MARK;
            end else begin
               state_in = S_PH_WR;
            end
         end
         S_PH_WR: begin
            tbl_we   = 1'b1;
            idx_in   = idx_ff - 1'b1;
            state_in = S_PH_RD;
         end
         S_A_MARK: begin
            state_in = S_A_MARKW;
         end
         S_A_MARKW: begin
            mk_we     = 1'b1;
            mk_wdata  = mk_rdata | (MWORD_W'(1) << h_ff[7:2]);
            status_in = ST_ALLOC;
            state_in  = S_DONE;
         end
         S_F_MARK: begin
            if (!mk_rdata[h_ff[7:2]]) begin
               status_in = ST_NOTALLOC;
               state_in  = S_DONE;
            end else if (count_ff >= CNT_W'(MAX_FREE_BLOCKS)) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               mk_we    = 1'b1;
               mk_wdata = mk_rdata & ~(MWORD_W'(1) << h_ff[7:2]);
               // only headers above this one count for the block end
               mword_in = mk_rdata & ({MWORD_W{1'b1}} << ({1'b0, h_ff[7:2]} + 7'd1));
               word_in  = h_ff[OFF_W-1:8];
               limit_in = SIZE_W'(ARENA_BYTES);
               idx_in   = '0;
               state_in = S_F_LRD;
            end
         end
         S_F_LRD: begin
            if (idx_ff >= count_ff) begin
               state_in = S_F_SCAN;
            end else begin
               state_in = S_F_LCHK;
            end
         end
         S_F_LCHK: begin
            if (rd_entry.start > h_ff && {1'b0, rd_entry.start} < limit_ff)
               limit_in = {1'b0, rd_entry.start};
            idx_in   = idx_ff + 1'b1;
            state_in = S_F_LRD;
         end
         S_F_SCAN: begin
            mk_raddr = nw[MARK_AW-1:0];
            if (low[6]) begin
               if ({1'b0, pos} < limit_ff) end_v = {1'b0, pos};
               do_push = 1'b1;
            end else if ({nw, 8'b0} >= limit_ff) begin
               do_push = 1'b1;
            end else begin
               word_in  = nw[MARK_AW-1:0];
               state_in = S_F_SCANW;
            end
            if (do_push) begin
               push_in.start = h_ff;
               push_in.size  = end_v - {1'b0, h_ff} - SIZE_W'(HEADER_BYTES);
               idx_in        = count_ff;
               state_in      = S_PH_RD;
            end
         end
         S_F_SCANW: begin
            mword_in = mk_rdata;
            state_in = S_F_SCAN;
         end
         S_C_INIT: begin
            idx_in   = '0;
            state_in = S_C_RD0;
         end
         S_C_RD0: begin
            if (idx_ff + 1'b1 >= count_ff) begin
               status_in = ST_FREED;
               state_in  = S_DONE;
            end else begin
               state_in = S_C_GET0;
            end
         end
         S_C_GET0: begin
            cur_in    = rd_entry;
            tbl_raddr = TBL_AW'(idx_ff + 1'b1);
            state_in  = S_C_GET1;
         end
         S_C_GET1: begin
            if (link == NEED_W'(rd_entry.start)) begin
               // merge successor into this entry, then drop it from the table
               tbl_we    = 1'b1;
               tbl_wdata = {cur_ff.start,
                            SIZE_W'(NEED_W'(cur_ff.size) + NEED_W'(HEADER_BYTES)
                                    + NEED_W'(rd_entry.size))};
               idx_in    = idx_ff + 1'b1;
               state_in  = S_RM_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_C_RD0;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_offset_in = (status_ff == ST_ALLOC) ?
                               OFF_W'(h_ff + OFF_W'(HEADER_BYTES)) : '0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         count_ff     <= CNT_W'(1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      kind_ff       <= kind_in;
      need_ff       <= need_in;
      h_ff          <= h_in;
      best_idx_ff   <= best_idx_in;
      best_start_ff <= best_start_in;
      best_size_ff  <= best_size_in;
      found_ff      <= found_in;
      cur_ff        <= cur_in;
      push_ff       <= push_in;
      limit_ff      <= limit_in;
      word_ff       <= word_in;
      mword_ff      <= mword_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_offset = rsp_offset_ff;

   `BFHA_ASSERT_NOW(a_count_max, 1'b1, count_ff <= CNT_W'(MAX_FREE_BLOCKS))
   `BFHA_ASSERT_NOW(a_offset_zero, rsp_valid_ff && rsp_status_ff != ST_ALLOC, rsp_offset_ff == '0)
   `BFHA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

endmodule

@@ test/best_fit_heap_allocator_checker.sv @@
// Checker for the best-fit heap allocator: predicts each response from accepted
// requests and compares it with the response channel. Depends on bfha_pkg.
module best_fit_heap_allocator_checker
   import bfha_pkg::*;
(
   input  logic              clock,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_kind,
   input  logic [REQ_W-1:0]  req_request_bytes,
   input  logic [REQ_W-1:0]  req_free_offset,
   input  logic              req_null_pointer,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [2:0]        rsp_status,
   input  logic [OFF_W-1:0]  rsp_block_offset,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]       status;
      logic [OFF_W-1:0] offset;
   } alloc_reply_type;

   int unsigned     blk_start[MAX_FREE_BLOCKS];
   int unsigned     blk_size[MAX_FREE_BLOCKS];
   int unsigned     blk_count;
   bit              hdr_mark[int];
   alloc_reply_type reply_q[$];

   initial begin
      blk_start[0] = 0;
      blk_size[0] = ARENA_BYTES - HEADER_BYTES;
      blk_count = 1;
      fail_count = 0;
   end

   assign pending = reply_q.size();

   function automatic void drop_entry(int unsigned idx);
      for (int unsigned i = idx; i + 1 < blk_count; i++) begin
         blk_start[i] = blk_start[i+1];
         blk_size[i] = blk_size[i+1];
      end
      blk_count--;
   endfunction

   function automatic void push_front(int unsigned s, int unsigned z);
      if (blk_count >= MAX_FREE_BLOCKS) return;
      for (int unsigned i = blk_count; i > 0; i--) begin
         blk_start[i] = blk_start[i-1];
         blk_size[i] = blk_size[i-1];
      end
      blk_start[0] = s;
      blk_size[0] = z;
      blk_count++;
   endfunction

   // end of the allocated block whose header sits at h
   function automatic int unsigned block_end(int unsigned h);
      int unsigned lim;
      int p;
      lim = ARENA_BYTES;
      for (int unsigned i = 0; i < blk_count; i++)
         if (blk_start[i] > h && blk_start[i] < lim) lim = blk_start[i];
      p = h;
      if (hdr_mark.next(p))
         if (p < lim) lim = p;
      return lim;
   endfunction

   function automatic void merge_neighbors();
      int unsigned i;
      i = 0;
      while (i + 1 < blk_count) begin
         if (blk_start[i] + HEADER_BYTES + blk_size[i] == blk_start[i+1]) begin
            blk_size[i] += HEADER_BYTES + blk_size[i+1];
            drop_entry(i + 1);
            i = 0;
         end else begin
            i++;
         end
      end
   endfunction

   function automatic alloc_reply_type predict_reply(logic kind, logic [REQ_W-1:0] nbytes,
                                                     logic [REQ_W-1:0] uoff, logic isnull);
      alloc_reply_type r;
      int unsigned need, best, bsz, h;
      bit found;
      r = '0;
      if (kind == 1'b0) begin
         if (nbytes == 0) begin
            r.status = ST_ZERO;
         end else begin
            need = (int'(nbytes) + ROUND_MASK) & ~ROUND_MASK;
            found = 0;
            best = 0;
            for (int unsigned i = 0; i < blk_count; i++)
               if (blk_size[i] >= need && (!found || blk_size[i] < blk_size[best])) begin
                  best = i;
                  found = 1;
               end
            if (!found) begin
               r.status = ST_NOFIT;
            end else begin
               h = blk_start[best];
               bsz = blk_size[best];
               drop_entry(best);
               if (bsz >= need + HEADER_BYTES + SPLIT_SLACK)
                  push_front(h + HEADER_BYTES + need, bsz - need - HEADER_BYTES);
               hdr_mark[h] = 1;
               r.status = ST_ALLOC;
               r.offset = OFF_W'(h + HEADER_BYTES);
            end
         end
      end else if (isnull) begin
         r.status = ST_NULL;
      end else if (uoff < HEADER_BYTES || uoff >= ARENA_BYTES) begin
         r.status = ST_INVALID;
      end else begin
         h = uoff - HEADER_BYTES;
         if (!hdr_mark.exists(h)) begin
            r.status = ST_NOTALLOC;
         end else if (blk_count >= MAX_FREE_BLOCKS) begin
            r.status = ST_FULL;
         end else begin
            bsz = block_end(h) - h - HEADER_BYTES;
            hdr_mark.delete(h);
            push_front(h, bsz);
            merge_neighbors();
            r.status = ST_FREED;
         end
      end
      return r;
   endfunction

   // inputs move only at rising edges, so the falling edge sees what the next
   // rising edge will accept
   always @(negedge clock) begin
      alloc_reply_type got, want;
      if (req_valid && !req_stall)
         reply_q.push_back(predict_reply(req_kind, req_request_bytes,
                                         req_free_offset, req_null_pointer));
      if (rsp_valid && !rsp_stall) begin
         got.status = rsp_status;
         got.offset = rsp_block_offset;
         if (reply_q.size() == 0) begin
            if (fail_count < 10)
               $display("%t: response with nothing expected: status %0d offset %0d",
                        $realtime, got.status, got.offset);
            fail_count++;
         end else begin
            want = reply_q.pop_front();
            if (got != want) begin
               if (fail_count < 10)
                  $display("%t: expected status %0d offset %0d, got status %0d offset %0d",
                           $realtime, want.status, want.offset, got.status, got.offset);
               fail_count++;
            end
         end
      end
   end

endmodule

@@ test/testbench.sv @@
// Top of the best-fit heap allocator testbench: clock, reset, stimulus and verdict.
// Depends on bfha_pkg, best_fit_heap_allocator and best_fit_heap_allocator_checker.
module testbench;
   import bfha_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 2000000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   logic              req_kind = 0;
   logic [REQ_W-1:0]  req_request_bytes = 0;
   logic [REQ_W-1:0]  req_free_offset = 0;
   logic              req_null_pointer = 0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   logic [2:0]        rsp_status;
   logic [OFF_W-1:0]  rsp_block_offset;
   int                fail_count, pending;

   bit  no_gaps = 0;
   int  hold_ticket = 0;
   int  live_ptrs[$];
   int  freed_ptrs[$];
   int  sent = 0;
   int  n_allocs = 0, n_frees = 0;

   always #1 clock = ~clock;

   best_fit_heap_allocator uut (.*);
   best_fit_heap_allocator_checker chk (.*);

   // keep the addresses handed out, for later frees
   always @(negedge clock)
      if (rsp_valid && !rsp_stall && rsp_status == ST_ALLOC)
         live_ptrs.push_back(rsp_block_offset);

   // watchdog on cycles with no transaction on either side
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(negedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("** best_fit_heap_allocator: FAILED **");
            $finish;
         end
      end
   end

   // response side
   initial begin
      int n, taken;
      bit acc;
      taken = 0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (hold_ticket != taken) begin
            taken = hold_ticket;
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
         end
         n = no_gaps ? 0 : $urandom_range(0, 13);
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
         do begin
            @(negedge clock);
            acc = rsp_valid;
            @(posedge clock);
         end while (!acc);
      end
   end

   task automatic send(logic kind, int nbytes, int uoff, logic isnull);
      int gap;
      bit acc;
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_request_bytes <= REQ_W'(nbytes);
      req_free_offset <= REQ_W'(uoff);
      req_null_pointer <= isnull;
      do begin
         @(negedge clock);
         acc = !req_stall;
         @(posedge clock);
      end while (!acc);
      sent++;
      if (kind) n_frees++;
      else n_allocs++;
   endtask

   task automatic alloc(int nbytes);
      send(1'b0, nbytes, $urandom_range(0, 20'hFFFFF), $urandom_range(0, 1));
   endtask

   task automatic release_ptr(int uoff);
      send(1'b1, $urandom_range(0, 20'hFFFFF), uoff, 1'b0);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic free_random_live();
      int k, p;
      k = $urandom_range(0, live_ptrs.size() - 1);
      p = live_ptrs[k];
      live_ptrs.delete(k);
      freed_ptrs.push_back(p);
      release_ptr(p);
   endtask

   initial begin
      int r, k;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes and all status codes except table-full
      alloc(0);
      alloc(20'hFFFFF);
      alloc(ARENA_BYTES - HEADER_BYTES + 1);
      alloc(ARENA_BYTES - HEADER_BYTES);           // whole arena, no fit once rounded up
      alloc(8);                                    // small block at the arena start
      send(1'b1, 20'hFFFFF, 20'hFFFFF, 1'b1);       // null pointer
      release_ptr(HEADER_BYTES - 1);
      release_ptr(ARENA_BYTES);
      release_ptr(20'hFFFFF);
      release_ptr(0);
      release_ptr(HEADER_BYTES + 1);                // interior pointer
      release_ptr(HEADER_BYTES);
      release_ptr(HEADER_BYTES);                    // double free
      alloc(ARENA_BYTES - HEADER_BYTES - 7);        // remainder too small to split
      release_ptr(HEADER_BYTES);
      alloc(1);
      alloc(100);
      alloc(20'h7FFF7);
      release_ptr(ARENA_BYTES - 1);
      drain();
      while (live_ptrs.size() > 0) free_random_live();
      drain();

      // random traffic
      for (int i = 0; i < 200; i++) begin
         if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if (i == 60) hold_ticket++;
         if (i == 130) drain();
         r = $urandom_range(0, 99);
         if (live_ptrs.size() > 60) r = r + 40;
         if (r < 55) begin
            k = $urandom_range(0, 99);
            if (k < 2) alloc(0);
            else if (k < 5) alloc($urandom_range(0, 20'hFFFFF));
            else if (k < 15) alloc($urandom_range(1, 8192));
            else alloc($urandom_range(1, 256));
         end else if (live_ptrs.size() > 0 && r < 130) begin
            free_random_live();
         end else begin
            k = $urandom_range(0, 3);
            if (k == 0) send(1'b1, $urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
                             1'b1);
            else if (k == 1) release_ptr($urandom_range(0, 20'hFFFFF));
            else if (k == 2 && freed_ptrs.size() > 0)
               release_ptr(freed_ptrs[$urandom_range(0, freed_ptrs.size() - 1)]);
            else release_ptr($urandom_range(0, 4095));
         end
      end
      drain();
      while (live_ptrs.size() > 0) free_random_live();
      drain();

      // fragment the arena until the free table fills, then send frees that the full table refuses
      no_gaps = 1;
      for (int i = 0; i < 514; i++) alloc($urandom_range(1, 8));
      drain();
      live_ptrs.sort();
      for (int i = 0; i < live_ptrs.size(); i += 2) release_ptr(live_ptrs[i]);
      for (int i = 1; i < live_ptrs.size(); i += 2) release_ptr(live_ptrs[i]);
      // the last even ones were refused while the table was full
      for (int i = 480; i < live_ptrs.size(); i += 2) release_ptr(live_ptrs[i]);
      drain();
      repeat (200) @(posedge clock);

      $display("Ran %0d requests: %0d allocates and %0d frees, incl. table-full",
               sent, n_allocs, n_frees);
      $display("fragmentation, long response stall and idle pauses; %0d mismatches",
               fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("** best_fit_heap_allocator: PASSED **");
      end else begin
         $display("** best_fit_heap_allocator: FAILED **");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/bfha_pkg.sv
design/bfha_ram.sv
design/best_fit_heap_allocator.sv
test/best_fit_heap_allocator_checker.sv
test/testbench.sv
